/* hdl/mexp_pkg.sv */
// Shared constants for the modular exponentiation core.
// Field widths, configuration register indexes. No dependencies.
package mexp_pkg;

  localparam int OPERAND_BITS   = 31;
  localparam int VALUE_BITS     = 32;
  localparam int REG_BITS       = 31;
  localparam int RESIDUE_BITS   = 31;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = CFG_INDEX_BITS'(1);

endpackage

/* hdl/mexp_if.sv */
// Valid/ready channel interfaces of the modular exponentiation core.
// Depends on mexp_pkg for field widths.
interface mexp_in_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::VALUE_BITS-1:0]   value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface mexp_out_if;
  logic                              valid;
  logic                              ready;
  logic [mexp_pkg::RESIDUE_BITS-1:0] residue;
  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

interface mexp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mexp_pkg::CFG_INDEX_BITS-1:0] index;
  logic [mexp_pkg::REG_BITS-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/mexp_reduce.sv */
// Bit-serial restoring remainder: value mod m, one value bit per cycle.
// Depends on mexp_pkg.
module mexp_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [mexp_pkg::VALUE_BITS-1:0]     value,
  input  logic [mexp_pkg::OPERAND_BITS-1:0]   m,
  output logic                                done,
  output logic [mexp_pkg::OPERAND_BITS-1:0]   rem
);
  localparam int W       = mexp_pkg::OPERAND_BITS;
  localparam int V       = mexp_pkg::VALUE_BITS;
  localparam int CntBits = $clog2(V + 1);

  logic [V-1:0]       v_sh_r;
  logic [W-1:0]       rem_r, rem_nxt;
  logic [CntBits-1:0] cnt_r;
  logic               done_r;
  logic [W:0]         rem_sh, diff;

  always_comb begin
    rem_sh = {rem_r, v_sh_r[V-1]};
    diff   = rem_sh - {1'b0, m};
    if (rem_sh >= {1'b0, m}) begin
      rem_nxt = diff[W-1:0];
    end else begin
      rem_nxt = rem_sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CntBits'(V);
        rem_r  <= '0;
        v_sh_r <= value;
      end else if (cnt_r != '0) begin
        rem_r  <= rem_nxt;
        v_sh_r <= {v_sh_r[V-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

/* hdl/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: a * b mod m, one bit of a per cycle.
// Requires a, b < m. Depends on mexp_pkg.
module mexp_mulmod (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] a,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] b,
  input  logic [mexp_pkg::OPERAND_BITS-1:0] m,
  output logic                              done,
  output logic [mexp_pkg::OPERAND_BITS-1:0] product
);
  localparam int W       = mexp_pkg::OPERAND_BITS;
  localparam int CntBits = $clog2(W + 1);

  logic [W-1:0]       a_sh_r;
  logic [W-1:0]       acc_r, acc_nxt;
  logic [CntBits-1:0] cnt_r;
  logic               done_r;
  logic [W+1:0]       t, m1, m2, d1, d2;

  always_comb begin
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + {2'b00, (a_sh_r[W-1] ? b : {W{1'b0}})};
    d1 = t - m1;
    d2 = t - m2;
    priority if (t >= m2) begin
      acc_nxt = d2[W-1:0];
    end else if (t >= m1) begin
      acc_nxt = d1[W-1:0];
    end else begin
      acc_nxt = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CntBits'(W);
        acc_r  <= '0;
        a_sh_r <= a;
      end else if (cnt_r != '0) begin
        acc_r  <= acc_nxt;
        a_sh_r <= {a_sh_r[W-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

/* hdl/modular_exponentiation_core.sv */
// Modular exponentiation core: residue = value ** exponent mod modulus.
// Right-to-left square-and-multiply over all OPERAND_BITS exponent bits. When the
// modulus is zero, the item goes straight to the output with a zero result.
// Otherwise the remainder of the value by the modulus comes first and is picked
// up as the base. Then, for each exponent bit, two one-bit-per-cycle modular
// multipliers work side by side (square and conditional multiply). Each such pass
// starts both multipliers and picks up their products. Last, the result register
// is loaded once it is empty or its result is taken. The next item can be accepted
// as soon as the result shows. One item is in work at a time; the result register
// frees the next item to enter while the previous result waits. Configuration
// writes are always taken.
// Depends on mexp_pkg, mexp_if, mexp_reduce, mexp_mulmod.
module modular_exponentiation_core (
  input  logic            clk,
  input  logic            rst_n,
  mexp_in_if.sink         in_if,
  mexp_out_if.source      out_if,
  mexp_cfg_if.sink        cfg_if
);
  localparam int W       = mexp_pkg::OPERAND_BITS;
  localparam int BitBits = $clog2(W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_OUT
  } state_t;

  state_t                              state_r;
  logic [W-1:0]                        exponent_r;
  logic [W-1:0]                        modulus_r;
  logic [W-1:0]                        e_sh_r;
  logic [W-1:0]                        acc_r;
  logic [W-1:0]                        base_r;
  logic [BitBits-1:0]                  bit_cnt_r;
  logic                                mul_start_r;
  logic                                out_valid_r;
  logic [mexp_pkg::RESIDUE_BITS-1:0]   residue_r;

  logic         in_acc;
  logic         out_load;
  logic         red_done;
  logic [W-1:0] red_rem;
  logic         sq_done, ml_done;
  logic [W-1:0] sq_res, ml_res;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  mexp_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .value (in_if.value),
    .m     (modulus_r),
    .done  (red_done),
    .rem   (red_rem)
  );

  mexp_mulmod u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (base_r),
    .b       (base_r),
    .m       (modulus_r),
    .done    (sq_done),
    .product (sq_res)
  );

  mexp_mulmod u_multiply (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (acc_r),
    .b       (base_r),
    .m       (modulus_r),
    .done    (ml_done),
    .product (ml_res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= '0;
      modulus_r  <= W'(1);
    end else if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index == mexp_pkg::CFG_EXPONENT) begin
        exponent_r <= cfg_if.data[W-1:0];
      end
      if (cfg_if.index == mexp_pkg::CFG_MODULUS) begin
        modulus_r <= cfg_if.data[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            e_sh_r    <= exponent_r;
            bit_cnt_r <= BitBits'(W);
            acc_r     <= (modulus_r > W'(1)) ? W'(1) : '0;
            if (modulus_r == '0) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (red_done) begin
            base_r      <= red_rem;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (sq_done && ml_done) begin
            base_r    <= sq_res;
            if (e_sh_r[0]) begin
              acc_r <= ml_res;
            end
            e_sh_r    <= {1'b0, e_sh_r[W-1:1]};
            bit_cnt_r <= bit_cnt_r - 1'b1;
            if (bit_cnt_r == BitBits'(1)) begin
              mul_start_r <= 1'b0;
              state_r     <= S_OUT;
            end else begin
              mul_start_r <= 1'b1;
            end
          end else begin
            mul_start_r <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_load) begin
            residue_r <= mexp_pkg::RESIDUE_BITS'(acc_r);
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready    = (state_r == S_IDLE);
  assign out_if.valid   = out_valid_r;
  assign out_if.residue = residue_r;
  assign cfg_if.ready   = 1'b1;
endmodule

/* hdl/mexp_checker.sv */
// Port-level checks for modular_exponentiation_core, attached by bind.
// Depends on mexp_pkg and the core's channel interfaces.
module mexp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mexp_pkg::RESIDUE_BITS-1:0] residue
);

  a_reset_no_item: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item shown right after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(residue)))
    else $error("stalled result dropped or changed");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .residue   (out_if.residue)
);

/* test/tb_top.sv */
// Self-checking testbench for modular_exponentiation_core: drives base values and
// register writes over valid/ready channels and checks every residue against a
// square-and-multiply predictor. Depends on mexp_pkg, mexp_if and the core.
`timescale 1ns / 100ps

module tb_top;

  localparam int          CLK_HALF      = 6;
  localparam int          CYCLE_LIMIT   = 3_000_000;
  localparam int          HOLD_CYCLES   = 4000;
  localparam int          DRAIN_CYCLES  = 1100;
  localparam int          RANDOM_SETS   = 12;
  localparam int          SET_ITEMS     = 46;
  localparam logic [mexp_pkg::REG_BITS-1:0]       REG_MAX        = '1;
  localparam logic [mexp_pkg::CFG_INDEX_BITS-1:0] CFG_INDEX_LAST = '1;

  logic clk;
  logic rst_n;

  mexp_in_if  in_if();
  mexp_out_if out_if();
  mexp_cfg_if cfg_if();

  modular_exponentiation_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  logic [mexp_pkg::VALUE_BITS-1:0]   value_q[$];
  logic [mexp_pkg::RESIDUE_BITS-1:0] residue_q[$];
  logic [mexp_pkg::REG_BITS-1:0]     exponent_model;
  logic [mexp_pkg::REG_BITS-1:0]     modulus_model;
  logic                    in_taken;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      hold_left;
  logic                    hold_req;
  logic                    hold_done;
  int                      cycle_cnt;
  int                      fail_cnt;
  int                      items_sent;
  int                      results_checked;
  int                      cfg_writes;

  function automatic logic [mexp_pkg::RESIDUE_BITS-1:0] modpow(
      logic [mexp_pkg::VALUE_BITS-1:0] base_in,
      logic [mexp_pkg::REG_BITS-1:0]   expo,
      logic [mexp_pkg::REG_BITS-1:0]   modu);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] base;
    if (modu == '0)
      return '0;
    m    = 64'(modu);
    acc  = 64'd1 % m;
    base = 64'(base_in) % m;
    for (int b = 0; b < mexp_pkg::OPERAND_BITS; b++) begin
      if (expo[b])
        acc = (acc * base) % m;
      base = (base * base) % m;
    end
    return acc[mexp_pkg::RESIDUE_BITS-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (in_if.valid && !in_taken) begin
      in_if.valid <= 1'b1;
    end else if (value_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_if.valid <= 1'b1;
      in_if.value <= value_q.pop_front();
      items_sent  <= items_sent + 1;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    logic [mexp_pkg::RESIDUE_BITS-1:0] want;
    cycle_cnt <= cycle_cnt + 1;
    in_taken  <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          mexp_pkg::CFG_EXPONENT: exponent_model <= cfg_if.data;
          mexp_pkg::CFG_MODULUS:  modulus_model  <= cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        residue_q.insert(residue_q.size(),
                         modpow(in_if.value, exponent_model, modulus_model));
      if (out_if.valid && out_if.ready) begin
        if (residue_q.size() == 0) begin
          $error("residue: no item expected, actual %0d", out_if.residue);
          fail_cnt++;
        end else begin
          want = residue_q.pop_front();
          results_checked++;
          if (out_if.residue !== want) begin
            $error("residue: expected %0d, actual %0d", want, out_if.residue);
            fail_cnt++;
          end
        end
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mexp_pkg::REG_BITS-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (value_q.size() != 0 || in_if.valid || residue_q.size() != 0);
  endtask

  function automatic logic [mexp_pkg::VALUE_BITS-1:0] pick_value();
    logic [mexp_pkg::VALUE_BITS-1:0] m;
    m = mexp_pkg::VALUE_BITS'(modulus_model);
    case ($urandom_range(5))
      0:       return mexp_pkg::VALUE_BITS'($urandom_range(0, 3));
      1:       return m + mexp_pkg::VALUE_BITS'($urandom_range(0, 2))
                        - mexp_pkg::VALUE_BITS'(1);
      2:       return m * mexp_pkg::VALUE_BITS'($urandom_range(0, 2))
                        + mexp_pkg::VALUE_BITS'($urandom_range(0, 1));
      3:       return ~mexp_pkg::VALUE_BITS'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [mexp_pkg::REG_BITS-1:0] pick_exponent(int set);
    case (set % 6)
      0:       return REG_MAX;
      1:       return '0;
      2:       return mexp_pkg::REG_BITS'(1);
      3:       return mexp_pkg::REG_BITS'($urandom_range(2, 255));
      default: return mexp_pkg::REG_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [mexp_pkg::REG_BITS-1:0] pick_modulus(int set);
    case (set % 6)
      0:       return REG_MAX;
      1:       return mexp_pkg::REG_BITS'(1);
      2:       return mexp_pkg::REG_BITS'(2);
      3:       return mexp_pkg::REG_BITS'($urandom_range(3, 1000));
      4:       return (set == 4) ? '0
                      : mexp_pkg::REG_BITS'($urandom()) | mexp_pkg::REG_BITS'(1);
      default: return mexp_pkg::REG_BITS'($urandom());
    endcase
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    exponent_model = '0;
    modulus_model  = mexp_pkg::REG_BITS'(1);
    in_taken       = 1'b0;
    send_idle_pct  = 11;
    recv_idle_pct  = 55;
    hold_left      = 0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    cycle_cnt      = 0;
    fail_cnt       = 0;
    items_sent     = 0;
    results_checked = 0;
    cfg_writes     = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unit modulus, zero exponent
    value_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_2345};
    wait_drained();
    // zero exponent gives one
    write_reg(mexp_pkg::CFG_MODULUS, mexp_pkg::REG_BITS'(7));
    value_q = '{32'd5, 32'd0};
    wait_drained();
    // writes to unused indexes are dropped
    write_reg(mexp_pkg::CFG_MODULUS + mexp_pkg::CFG_INDEX_BITS'(1), '0);
    write_reg(CFG_INDEX_LAST, REG_MAX);
    value_q = '{32'd3};
    wait_drained();
    write_reg(mexp_pkg::CFG_EXPONENT, REG_MAX);
    write_reg(mexp_pkg::CFG_MODULUS, REG_MAX);
    value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000};
    wait_drained();
    write_reg(mexp_pkg::CFG_EXPONENT, mexp_pkg::REG_BITS'(1));
    write_reg(mexp_pkg::CFG_MODULUS, mexp_pkg::REG_BITS'(2));
    value_q = '{32'd2, 32'd3};
    wait_drained();
    write_reg(mexp_pkg::CFG_EXPONENT, REG_MAX);
    write_reg(mexp_pkg::CFG_MODULUS, mexp_pkg::REG_BITS'(1));
    value_q = '{32'd9};
    wait_drained();
    // zero modulus
    write_reg(mexp_pkg::CFG_MODULUS, '0);
    value_q = '{32'd0, 32'hFFFF_FFFF, 32'd42};
    wait_drained();
    write_reg(mexp_pkg::CFG_EXPONENT, '0);
    value_q = '{32'd5};
    wait_drained();

    for (int set = 0; set < RANDOM_SETS; set++) begin
      case (set / 4)
        0:       begin send_idle_pct = 11; recv_idle_pct = 55; end
        1:       begin send_idle_pct = 55; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_reg(mexp_pkg::CFG_EXPONENT, pick_exponent(set));
      write_reg(mexp_pkg::CFG_MODULUS, pick_modulus(set));
      if (set % 3 == 2)
        write_reg(mexp_pkg::CFG_INDEX_BITS'($urandom_range(mexp_pkg::CFG_MODULUS + 1,
                                                           CFG_INDEX_LAST)),
                  mexp_pkg::REG_BITS'($urandom()));
      @(negedge clk);
      for (int k = 0; k < SET_ITEMS; k++)
        value_q.insert(value_q.size(), pick_value());
      if (set == 9)
        hold_req = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d items over %0d register writes; checked %0d residues.",
             items_sent, cfg_writes, results_checked);
    $display("Covered zero and unit modulus, extreme exponents and one long output stall.");
    if (fail_cnt == 0 && residue_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mexp_pkg.sv
hdl/mexp_if.sv
hdl/mexp_reduce.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation_core.sv
hdl/mexp_checker.sv
test/tb_top.sv
